// ----- hdl/per_cpu_page_free_list_allocator_macros.svh -----
// Assertion macros shared by the page allocator RTL.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/pcpfa_pkg.sv -----
// Shared types and constants of the per-CPU page free-list allocator.
`timescale 1ns / 1ps
package pcpfa_pkg;

  // Default sizes of the allocator.
  localparam int NUM_CPUS_DEF  = 8;
  localparam int MAX_PAGES_DEF = 32768;

  // Address layout: 4 KiB pages in a 32-bit physical space.
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PN_W       = ADDR_W - PAGE_SHIFT;
  localparam int BASE_W     = PN_W + 1;
  localparam int UNIT_W     = ADDR_W + 1;
  localparam int CPU_IN_W   = 3;

  // Stream widths; the data words are padded to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;

  // Configuration register map.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP   = 1'b1;
  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] REGION_TOP_RST   = 32'h8800_0000;

  // Operation carried in tuser.
  typedef enum logic {
    KIND_FREE  = 1'b0,
    KIND_ALLOC = 1'b1
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_OOM  = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_LO,
    ST_F_HI,
    ST_F_BASE,
    ST_F_IDX,
    ST_F_RANGE,
    ST_F_PUSH,
    ST_A_PICK,
    ST_A_HEAD,
    ST_A_POP
  } state_e;

endpackage

// ----- hdl/per_cpu_page_free_list_allocator.sv -----
// Per-CPU LIFO page free-list allocator with stealing from the lowest non-empty list.
`timescale 1ns / 1ps
// One input word is a free (kind 0) or an allocate (kind 1) for one CPU; every word
// gives exactly one result word. The block takes one word at a time. A free runs its
// checks and its page index one after another through a single 33-bit add/subtract
// unit (below region_start with the alignment test, at or above region_top, base
// page, page index, page store range), then reads the list head and pushes the page.
// Its result is loaded in the push step, and the next word can be accepted in the
// cycle after that. An allocate picks the list and reads its head from the head
// memory, forms the address and reads the next link from the link memory, then
// pops. Its result is loaded in the pop step; an out of memory result is loaded
// already in the head step. A result waits in the output register while the next
// word is already accepted; the final step stalls only if that register is still
// full. The link memory needs no clearing pass, so the block is ready right after
// reset. Configuration writes are taken in any cycle and must only be issued
// while the block is idle.
`include "per_cpu_page_free_list_allocator_macros.svh"
module per_cpu_page_free_list_allocator #(
  parameter int NUM_CPUS  = pcpfa_pkg::NUM_CPUS_DEF,
  parameter int MAX_PAGES = pcpfa_pkg::MAX_PAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream; tdata: cpu[2:0], page_address[34:3], zero pad[39:35].
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [pcpfa_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: kind[0].
  input  logic [pcpfa_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  // Result stream; tdata: status[1:0], granted_address[33:2], source_cpu[36:34],
  // zero pad[39:37].
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [pcpfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcpfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcpfa_pkg::ADDR_W-1:0]        cfg_data_i
);

  localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int AW     = pcpfa_pkg::ADDR_W;
  localparam int PS     = pcpfa_pkg::PAGE_SHIFT;
  localparam int PN_W   = pcpfa_pkg::PN_W;
  localparam int BW     = pcpfa_pkg::BASE_W;
  localparam int UW     = pcpfa_pkg::UNIT_W;
  localparam int CIW    = pcpfa_pkg::CPU_IN_W;

  // Configuration registers.
  logic [AW-1:0] region_start_q, region_top_q;

  // Sequencer and item registers.
  pcpfa_pkg::state_e state_q, state_d;
  logic              kind_q;
  logic [CPU_W-1:0]  cpu_q;
  logic [AW-1:0]     addr_q;

  // Working registers.
  logic              bad_q, bad_d;
  logic [BW-1:0]     base_q, base_d;
  logic [BW-1:0]     idx_q, idx_d;
  logic              found_q, found_d;
  logic [CPU_W-1:0]  from_q, from_d;
  logic [AW-1:0]     grant_q, grant_d;

  // List state: head valid bits in flops, heads and links in memories.
  logic [NUM_CPUS-1:0] head_ok_q, head_ok_d;
  logic [PAGE_W-1:0]   head_mem [NUM_CPUS];
  logic [PAGE_W:0]     link_mem [MAX_PAGES];
  logic [PAGE_W-1:0]   head_rd_q;
  logic [PAGE_W:0]     link_rd_q;
  logic                head_rd_en, link_rd_en, head_we, link_we;
  logic [CPU_W-1:0]    head_rd_addr, head_waddr;
  logic [PAGE_W-1:0]   head_wdata;
  logic [PAGE_W-1:0]   link_waddr;
  logic [PAGE_W:0]     link_wdata;

  // Output register.
  logic                   out_valid_q;
  pcpfa_pkg::status_e     out_status_q, res_status;
  logic [AW-1:0]          out_grant_q, res_grant;
  logic [CIW-1:0]         out_source_q, res_source;
  logic                   out_free, out_load;

  // Shared add/subtract unit.
  logic [UW-1:0] unit_a, unit_b, unit_sum;
  logic          unit_sub, unit_cin, unit_borrow;

  // Input handshake and CPU number folded into range.
  logic             in_fire;
  logic [CIW-1:0]   cpu_red;
  logic [NUM_CPUS-1:0] lowest_oh;
  logic [CPU_W-1:0] low_idx;

  assign s_axis_tready_o = (state_q == pcpfa_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Reduce the CPU number modulo the list count by repeated subtraction.
  always_comb begin
    cpu_red = s_axis_tdata_i[CIW-1:0];
    for (int k = 0; k < 7; k++) begin
      if (int'(cpu_red) >= NUM_CPUS) begin
        cpu_red = cpu_red - CIW'(NUM_CPUS);
      end
    end
  end

  // Lowest non-empty list: isolate the lowest valid bit, then encode it.
  always_comb begin
    lowest_oh = head_ok_q & (~head_ok_q + NUM_CPUS'(1));
    low_idx   = '0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (lowest_oh[i]) begin
        low_idx = low_idx | CPU_W'(i);
      end
    end
  end

  // The shared unit: a plus or minus b, with an optional carry in.
  assign unit_sum    = unit_a + (unit_sub ? ~unit_b : unit_b) + UW'(unit_sub | unit_cin);
  assign unit_borrow = unit_sum[UW-1];

  // Sequencer: next state, unit operands, memory controls and result.
  always_comb begin
    state_d      = state_q;
    bad_d        = bad_q;
    base_d       = base_q;
    idx_d        = idx_q;
    found_d      = found_q;
    from_d       = from_q;
    grant_d      = grant_q;
    head_ok_d    = head_ok_q;
    unit_a       = '0;
    unit_b       = '0;
    unit_sub     = 1'b0;
    unit_cin     = 1'b0;
    head_rd_en   = 1'b0;
    head_rd_addr = cpu_q;
    link_rd_en   = 1'b0;
    head_we      = 1'b0;
    head_waddr   = cpu_q;
    head_wdata   = idx_q[PAGE_W-1:0];
    link_we      = 1'b0;
    link_waddr   = idx_q[PAGE_W-1:0];
    link_wdata   = {head_ok_q[cpu_q], head_rd_q};
    out_load     = 1'b0;
    res_status   = pcpfa_pkg::STAT_DONE;
    res_grant    = '0;
    res_source   = '0;
    unique case (state_q)
      pcpfa_pkg::ST_IDLE: begin
        if (in_fire) begin
          bad_d = 1'b0;
          if (s_axis_tuser_i[0] == pcpfa_pkg::KIND_ALLOC) begin
            state_d = pcpfa_pkg::ST_A_PICK;
          end else begin
            state_d = pcpfa_pkg::ST_F_LO;
          end
        end
      end
      // Free: below region_start or not page aligned.
      pcpfa_pkg::ST_F_LO: begin
        unit_a   = UW'(addr_q);
        unit_b   = UW'(region_start_q);
        unit_sub = 1'b1;
        bad_d    = unit_borrow | (|addr_q[PS-1:0]);
        state_d  = pcpfa_pkg::ST_F_HI;
      end
      // Free: at or above region_top.
      pcpfa_pkg::ST_F_HI: begin
        unit_a   = UW'(addr_q);
        unit_b   = UW'(region_top_q);
        unit_sub = 1'b1;
        bad_d    = bad_q | !unit_borrow;
        state_d  = pcpfa_pkg::ST_F_BASE;
      end
      // Base page number, rounding region_start up to a page.
      pcpfa_pkg::ST_F_BASE: begin
        unit_a   = UW'(region_start_q[AW-1:PS]);
        unit_cin = |region_start_q[PS-1:0];
        base_d   = unit_sum[BW-1:0];
        state_d  = pcpfa_pkg::ST_F_IDX;
      end
      // Page index relative to the base.
      pcpfa_pkg::ST_F_IDX: begin
        unit_a   = UW'(addr_q[AW-1:PS]);
        unit_b   = UW'(base_q);
        unit_sub = 1'b1;
        idx_d    = unit_sum[BW-1:0];
        state_d  = pcpfa_pkg::ST_F_RANGE;
      end
      // Index must fall inside the page store; fetch the current head.
      pcpfa_pkg::ST_F_RANGE: begin
        unit_a     = UW'(idx_q);
        unit_b     = UW'(MAX_PAGES);
        unit_sub   = 1'b1;
        bad_d      = bad_q | !unit_borrow;
        head_rd_en = 1'b1;
        state_d    = pcpfa_pkg::ST_F_PUSH;
      end
      // Push: the old head becomes the link of the freed page.
      pcpfa_pkg::ST_F_PUSH: begin
        res_status = bad_q ? pcpfa_pkg::STAT_BAD : pcpfa_pkg::STAT_DONE;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = pcpfa_pkg::ST_IDLE;
          if (!bad_q) begin
            link_we          = 1'b1;
            head_we          = 1'b1;
            head_ok_d[cpu_q] = 1'b1;
          end
        end
      end
      // Allocate: own list first, else the lowest non-empty one.
      pcpfa_pkg::ST_A_PICK: begin
        found_d      = |head_ok_q;
        from_d       = head_ok_q[cpu_q] ? cpu_q : low_idx;
        head_rd_en   = 1'b1;
        head_rd_addr = from_d;
        unit_a       = UW'(region_start_q[AW-1:PS]);
        unit_cin     = |region_start_q[PS-1:0];
        base_d       = unit_sum[BW-1:0];
        state_d      = pcpfa_pkg::ST_A_HEAD;
      end
      // Head page known: form its address and fetch its link.
      pcpfa_pkg::ST_A_HEAD: begin
        if (!found_q) begin
          res_status = pcpfa_pkg::STAT_OOM;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = pcpfa_pkg::ST_IDLE;
          end
        end else begin
          unit_a     = UW'(base_q);
          unit_b     = UW'(head_rd_q);
          grant_d    = {unit_sum[PN_W-1:0], {PS{1'b0}}};
          link_rd_en = 1'b1;
          state_d    = pcpfa_pkg::ST_A_POP;
        end
      end
      // Pop: the link becomes the new head of the source list.
      pcpfa_pkg::ST_A_POP: begin
        res_grant  = grant_q;
        res_source = CIW'(from_q);
        if (out_free) begin
          out_load          = 1'b1;
          head_we           = 1'b1;
          head_waddr        = from_q;
          head_wdata        = link_rd_q[PAGE_W-1:0];
          head_ok_d[from_q] = link_rd_q[PAGE_W];
          state_d           = pcpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcpfa_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pcpfa_pkg::ST_IDLE;
      head_ok_q      <= '0;
      out_valid_q    <= 1'b0;
      region_start_q <= pcpfa_pkg::REGION_START_RST;
      region_top_q   <= pcpfa_pkg::REGION_TOP_RST;
    end else begin
      state_q   <= state_d;
      head_ok_q <= head_ok_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pcpfa_pkg::REG_REGION_START: region_start_q <= cfg_data_i;
          pcpfa_pkg::REG_REGION_TOP:   region_top_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= s_axis_tuser_i[0];
      cpu_q  <= CPU_W'(cpu_red);
      addr_q <= s_axis_tdata_i[CIW +: AW];
    end
    bad_q   <= bad_d;
    base_q  <= base_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    from_q  <= from_d;
    grant_q <= grant_d;
    if (out_load) begin
      out_status_q <= res_status;
      out_grant_q  <= res_grant;
      out_source_q <= res_source;
    end
  end

  // Head memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_rd_en) begin
      head_rd_q <= head_mem[head_rd_addr];
    end
  end

  // Link memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_rd_en) begin
      link_rd_q <= link_mem[head_rd_q];
    end
  end

  // Result word.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = pcpfa_pkg::OUT_DATA_W'({out_source_q, out_grant_q, out_status_q});

  // A rejected free must not touch any list.
  `PFA_ASSERT(a_bad_free_keeps_lists,
    (state_q == pcpfa_pkg::ST_F_PUSH && bad_q) |=> $stable(head_ok_q),
    "rejected free changed the list state")

  // A pushed page always lies inside the page store.
  `PFA_ASSERT(a_push_in_range,
    (state_q == pcpfa_pkg::ST_F_PUSH && !bad_q) |-> (idx_q < BW'(MAX_PAGES)),
    "page index outside the page store reached the push step")

  // Out of memory is only reported when every list is empty.
  `PFA_ASSERT(a_oom_only_when_empty,
    (out_load && res_status == pcpfa_pkg::STAT_OOM) |-> (head_ok_q == '0),
    "out of memory reported with a non-empty list")

  // Only an allocate reaches the pop step, and its source list was valid.
  `PFA_ASSERT(a_pop_from_valid_list,
    (state_q == pcpfa_pkg::ST_A_POP) |-> (kind_q == pcpfa_pkg::KIND_ALLOC && head_ok_q[from_q]),
    "pop from an empty list or for a free word")

  // Reset leaves no result pending.
  `PFA_ASSERT_ALWAYS(a_reset_clears_output,
    !rst_ni |-> !m_axis_tvalid_o,
    "result valid while in reset")

endmodule
